// File: design/bmbm_pkg.sv
// ----------------------------------------------------------------------------
// bmbm_pkg: shared types and constants for the bus mapped byte memory
// Operation, status and write policy codes, register map and the
// configuration bundle passed from the register block to the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bmbm_pkg;

	// field widths
	localparam int ADDR_W     = 64;
	localparam int DATA_W     = 64;
	localparam int LEN_W      = 4;
	localparam int OP_W       = 2;
	localparam int ST_W       = 2;
	localparam int SIZE_CFG_W = 17;
	localparam int POL_W      = 2;
	localparam int LANE_W     = 3;

	// stream payload widths (tdata padded to whole bytes)
	localparam int S_TDATA_W = 136;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 64;
	localparam int M_TUSER_W = 2;

	// configuration port
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 64;
	localparam int REG_IDX_W  = 2;

	// default built capacity in bytes
	localparam int DEF_MEM_BYTES = 65536;

	// operation codes
	localparam logic [OP_W-1:0] OP_READ    = 2'd0;
	localparam logic [OP_W-1:0] OP_FETCH   = 2'd1;
	localparam logic [OP_W-1:0] OP_WRITE   = 2'd2;
	localparam logic [OP_W-1:0] OP_INVALID = 2'd3;

	// status codes
	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_INVALID   = 2'd1;
	localparam logic [ST_W-1:0] ST_UNMAPPED  = 2'd2;
	localparam logic [ST_W-1:0] ST_READ_ONLY = 2'd3;

	// write policies
	localparam logic [POL_W-1:0] POL_WRITABLE = 2'd0;
	localparam logic [POL_W-1:0] POL_REJECT   = 2'd1;
	localparam logic [POL_W-1:0] POL_IGNORE   = 2'd2;

	// register indexes (byte address = 8 * index)
	localparam logic [REG_IDX_W-1:0] REG_BASE   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SIZE   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_POLICY = 2'd2;

	// register reset values
	localparam logic [ADDR_W-1:0]     RST_BASE   = '0;
	localparam logic [SIZE_CFG_W-1:0] RST_SIZE   = 17'h10000;
	localparam logic [POL_W-1:0]      RST_POLICY = 2'd0;

	// configuration bundle
	typedef struct packed {
		logic [ADDR_W-1:0]     base_address;
		logic [SIZE_CFG_W-1:0] mem_size;
		logic [POL_W-1:0]      wr_policy;
	} cfg_t;

endpackage

`default_nettype wire

// File: design/bmbm_regs.sv
// ----------------------------------------------------------------------------
// bmbm_regs: configuration registers
// APB-style slave holding base address, size in use and write policy.
// Always ready; writes land on the access phase, reads are combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module bmbm_regs (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire [bmbm_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire [bmbm_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [bmbm_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	output bmbm_pkg::cfg_t                   cfg
);
	import bmbm_pkg::*;

	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;
	cfg_t                 cfg_q;

	assign pready = 1'b1;
	assign idx    = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_address <= RST_BASE;
			cfg_q.mem_size     <= RST_SIZE;
			cfg_q.wr_policy    <= RST_POLICY;
		end else if (wr_en) begin
			case (idx)
				REG_BASE:   cfg_q.base_address <= pwdata[ADDR_W-1:0];
				REG_SIZE:   cfg_q.mem_size     <= pwdata[SIZE_CFG_W-1:0];
				REG_POLICY: cfg_q.wr_policy    <= pwdata[POL_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_BASE:   prdata = APB_DATA_W'(cfg_q.base_address);
			REG_SIZE:   prdata = APB_DATA_W'(cfg_q.mem_size);
			REG_POLICY: prdata = APB_DATA_W'(cfg_q.wr_policy);
			default:    prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: design/bmbm_ram.sv
// ----------------------------------------------------------------------------
// bmbm_ram: byte-wide single-port memory
// One access per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bmbm_ram #(
	parameter int MEM_BYTES = 65536,
	parameter int AW        = 16
) (
	input  wire           clk,
	input  wire           we,
	input  wire [AW-1:0]  addr,
	input  wire [7:0]     wdata,
	output logic [7:0]    rdata
);

	logic [7:0] mem [MEM_BYTES];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

// File: design/bmbm_ctrl.sv
// ----------------------------------------------------------------------------
// bmbm_ctrl: access sequencer
// Clears the memory after reset, checks each access (length, base, range,
// policy, operation), then walks the bytes of a passing access one per cycle
// and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmbm_ctrl #(
	parameter int MEM_BYTES = 65536,
	parameter int AW        = 16
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  bmbm_pkg::cfg_t                   cfg,
	// request stream
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire [bmbm_pkg::S_TDATA_W-1:0]    s_tdata,
	input  wire [bmbm_pkg::S_TUSER_W-1:0]    s_tuser,
	// result stream
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [bmbm_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic [bmbm_pkg::M_TUSER_W-1:0]   m_tuser,
	// memory port
	output logic                             mem_we,
	output logic [AW-1:0]                    mem_addr,
	output logic [7:0]                       mem_wdata,
	input  wire [7:0]                        mem_rdata
);
	import bmbm_pkg::*;

	localparam int CAP_W  = $clog2(MEM_BYTES + 1);
	localparam int SIZE_W = (CAP_W > SIZE_CFG_W) ? CAP_W : SIZE_CFG_W;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_CHECK  = 3'd2;
	localparam logic [2:0] S_RANGE  = 3'd3;
	localparam logic [2:0] S_ACCESS = 3'd4;
	localparam logic [2:0] S_DRAIN  = 3'd5;
	localparam logic [2:0] S_FINISH = 3'd6;

	logic [2:0]        state_q;
	logic [AW-1:0]     clr_q;

	// captured request
	logic [OP_W-1:0]   op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]  len_q;
	logic              big_q;
	logic [DATA_W-1:0] wdata_q;

	// check results
	logic [ADDR_W-1:0] offset_q;
	logic              inval_q;
	logic              is_wr_q;
	logic [ST_W-1:0]   st_q;

	// byte walk
	logic [AW-1:0]     baddr_q;
	logic [LANE_W-1:0] cnt_q;
	logic [DATA_W-1:0] rdata_q;
	logic              rd_v_s1;
	logic [LANE_W-1:0] lane_s1;

	// output register
	logic              m_tvalid_q;
	logic [DATA_W-1:0] m_data_q;
	logic [ST_W-1:0]   m_st_q;

	logic [LANE_W-1:0] lane;
	logic [LEN_W-1:0]  len_m1;
	logic              last_byte;
	logic [SIZE_W-1:0] used_size;
	logic [SIZE_W:0]   end_sum;
	logic              unmapped;
	logic              out_free;
	logic              out_load;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_st_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = (state_q == S_FINISH) && out_free;

	// byte lane for the current step: reversed for big-endian
	assign len_m1    = len_q - LEN_W'(1);
	assign last_byte = ({1'b0, cnt_q} == len_m1);
	assign lane      = big_q ? LANE_W'(len_m1 - {1'b0, cnt_q}) : cnt_q;

	// range check: size clamped to capacity, whole access must fit
	assign used_size = (SIZE_W'(cfg.mem_size) > SIZE_W'(MEM_BYTES)) ?
		SIZE_W'(MEM_BYTES) : SIZE_W'(cfg.mem_size);
	assign end_sum   = {1'b0, offset_q[SIZE_W-1:0]} + (SIZE_W+1)'(len_q);
	assign unmapped  = (|offset_q[ADDR_W-1:SIZE_W]) || (end_sum > {1'b0, used_size});

	// memory port
	always_comb begin
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '0;
			end
			S_ACCESS: begin
				mem_we    = is_wr_q;
				mem_addr  = baddr_q;
				mem_wdata = wdata_q[{lane, 3'b000} +: 8];
			end
			default: begin
				mem_we    = 1'b0;
				mem_addr  = baddr_q;
				mem_wdata = '0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			rd_v_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == S_ACCESS) && !is_wr_q;
			// output register: load on finish, else clear on transfer
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MEM_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= S_RANGE;
				end
				S_RANGE: begin
					if (inval_q || unmapped) begin
						state_q <= S_FINISH;
					end else if (op_q == OP_WRITE) begin
						if (cfg.wr_policy == POL_REJECT ||
							cfg.wr_policy == POL_IGNORE) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_ACCESS;
						end
					end else if (op_q == OP_INVALID) begin
						state_q <= S_FINISH;
					end else begin
						state_q <= S_ACCESS;
					end
				end
				S_ACCESS: begin
					if (last_byte) begin
						state_q <= is_wr_q ? S_FINISH : S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q    <= s_tuser[OP_W-1:0];
				big_q   <= s_tuser[OP_W];
				addr_q  <= s_tdata[ADDR_W-1:0];
				len_q   <= s_tdata[ADDR_W +: LEN_W];
				wdata_q <= s_tdata[ADDR_W+LEN_W +: DATA_W];
				rdata_q <= '0;
			end
			S_CHECK: begin
				// base check and length check
				offset_q <= addr_q - cfg.base_address;
				inval_q  <= (addr_q < cfg.base_address) || (len_q == '0) ||
					(len_q > LEN_W'(8));
			end
			S_RANGE: begin
				baddr_q <= offset_q[AW-1:0];
				cnt_q   <= '0;
				is_wr_q <= (op_q == OP_WRITE);
				if (inval_q) begin
					st_q <= ST_INVALID;
				end else if (unmapped) begin
					st_q <= ST_UNMAPPED;
				end else if (op_q == OP_WRITE) begin
					st_q <= (cfg.wr_policy == POL_REJECT) ? ST_READ_ONLY : ST_OK;
				end else if (op_q == OP_INVALID) begin
					st_q <= ST_INVALID;
				end else begin
					st_q <= ST_OK;
				end
			end
			S_ACCESS: begin
				baddr_q <= baddr_q + AW'(1);
				cnt_q   <= cnt_q + LANE_W'(1);
				lane_s1 <= lane;
			end
			S_FINISH: begin
				if (out_free) begin
					m_data_q <= rdata_q;
					m_st_q   <= st_q;
				end
			end
			default: ;
		endcase
		// read data lands in the cycle after its address
		if (rd_v_s1) begin
			rdata_q[{lane_s1, 3'b000} +: 8] <= mem_rdata;
		end
	end

endmodule

`default_nettype wire

// File: design/bus_mapped_byte_memory.sv
// ----------------------------------------------------------------------------
// bus_mapped_byte_memory: byte memory mapped at a configurable base address
// Accepts read, fetch and write accesses of 1 to 8 bytes in either byte
// order, checks them against base, size and write policy, and returns one
// status and read value per access.
//
//   Channel  Dir  Handshake          Contents
//   s_*      in   s_tvalid/s_tready  one access request
//   m_*      out  m_tvalid/m_tready  status and read data
//   APB      in   psel/penable       base_address, mem_size, wr_policy
//
// After reset the memory is swept to zero, one byte per cycle, and no
// request is taken during the sweep; register writes are always taken.
// A request passes check and range steps, then finishes if a check fails
// or a write is suppressed, else the byte-wide port walks its bytes one per
// cycle (a read drains its last byte). A new request is taken while a result
// waits; the sequencer stalls at its end only if the output register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module bus_mapped_byte_memory #(
	parameter int MEM_BYTES = bmbm_pkg::DEF_MEM_BYTES
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// request stream
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// [63:0] address, [67:64] access_bytes, [131:68] write_data
	input  wire [bmbm_pkg::S_TDATA_W-1:0]    s_tdata,
	// [1:0] operation, [2] big_endian
	input  wire [bmbm_pkg::S_TUSER_W-1:0]    s_tuser,
	// result stream
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// [63:0] read_data
	output logic [bmbm_pkg::M_TDATA_W-1:0]   m_tdata,
	// [1:0] status
	output logic [bmbm_pkg::M_TUSER_W-1:0]   m_tuser,
	// configuration
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire [bmbm_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire [bmbm_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [bmbm_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready
);
	import bmbm_pkg::*;

	localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

	cfg_t          cfg;
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata;
	logic [7:0]    mem_rdata;

	bmbm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bmbm_ram #(
		.MEM_BYTES (MEM_BYTES),
		.AW        (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	bmbm_ctrl #(
		.MEM_BYTES (MEM_BYTES),
		.AW        (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

endmodule

`default_nettype wire
